FILE: hdl/rdsgrp_pkg.sv
package rdsgrp_pkg;

   localparam int MAX_CHUNK_BITS = 32;
   localparam int BLOCK_BITS     = 26;
   localparam int DATA_W         = 32;
   localparam int COUNT_W        = 6;
   localparam int SEEN_W         = 5;
   localparam int SYN_W          = 10;
   localparam int INFO_W         = 16;
   localparam int KIND_W         = 5;

   localparam logic [COUNT_W-1:0] CHUNK_LIMIT = COUNT_W'(MAX_CHUNK_BITS);
   localparam logic [SEEN_W-1:0]  SEEN_FULL   = SEEN_W'(BLOCK_BITS);

   // expected block position inside a group
   localparam logic [1:0] BLK_A = 2'd0;
   localparam logic [1:0] BLK_B = 2'd1;
   localparam logic [1:0] BLK_C = 2'd2;
   localparam logic [1:0] BLK_D = 2'd3;

   // syndrome match codes
   localparam logic [2:0] MATCH_A    = 3'd0;
   localparam logic [2:0] MATCH_B    = 3'd1;
   localparam logic [2:0] MATCH_C    = 3'd2;
   localparam logic [2:0] MATCH_D    = 3'd3;
   localparam logic [2:0] MATCH_CP   = 3'd4;
   localparam logic [2:0] MATCH_NONE = 3'd5;

   localparam logic [SYN_W-1:0] OFS_A  = 10'h3d8;
   localparam logic [SYN_W-1:0] OFS_B  = 10'h3d4;
   localparam logic [SYN_W-1:0] OFS_C  = 10'h25c;
   localparam logic [SYN_W-1:0] OFS_D  = 10'h258;
   localparam logic [SYN_W-1:0] OFS_CP = 10'h3cc;

   // parity check rows, first entry belongs to the window MSB
   localparam logic [SYN_W-1:0] PARITY_ROWS [BLOCK_BITS] = '{
      10'h200, 10'h100, 10'h080, 10'h040, 10'h020, 10'h010, 10'h008, 10'h004,
      10'h002, 10'h001, 10'h2dc, 10'h16e, 10'h0b7, 10'h287, 10'h39f, 10'h313,
      10'h355, 10'h376, 10'h1bb, 10'h201, 10'h3dc, 10'h1ee, 10'h0f7, 10'h2a7,
      10'h38f, 10'h31b
   };

   typedef struct packed {
      logic [DATA_W-1:0]  data;
      logic [COUNT_W-1:0] count;
   } chunk_type;

   function automatic logic [SYN_W-1:0] syndrome(input logic [BLOCK_BITS-1:0] w);
      logic [SYN_W-1:0] syn;
      syn = '0;
      for (int i = 0; i < BLOCK_BITS; i++) begin
         if (w[i]) begin
            syn = syn ^ PARITY_ROWS[BLOCK_BITS-1-i];
         end
      end
      return syn;
   endfunction

   function automatic logic [2:0] classify(input logic [BLOCK_BITS-1:0] w);
      logic [SYN_W-1:0] syn;
      logic [2:0]       code;
      syn = syndrome(w);
      if (syn == OFS_A)       code = MATCH_A;
      else if (syn == OFS_B)  code = MATCH_B;
      else if (syn == OFS_C)  code = MATCH_C;
      else if (syn == OFS_D)  code = MATCH_D;
      else if (syn == OFS_CP) code = MATCH_CP;
      else                    code = MATCH_NONE;
      return code;
   endfunction

endpackage

FILE: hdl/rdsgrp_front.sv
module rdsgrp_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [rdsgrp_pkg::DATA_W-1:0]  req_data_bits,
   input  logic [rdsgrp_pkg::COUNT_W-1:0] req_bit_count,
   output logic                         q_valid,
   input  logic                         q_ready,
   output rdsgrp_pkg::chunk_type        q_chunk
);
   import rdsgrp_pkg::*;

   chunk_type   queue_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  fill_ff, fill_in;
   logic        accept, push, pop;
   chunk_type   chunk_in;

   assign req_ready = (fill_ff != 2'd2);
   assign accept    = req_valid && req_ready;
   // drop empty items, they cannot change any state
   assign push      = accept && (req_bit_count != '0);
   assign q_valid   = (fill_ff != 2'd0);
   assign pop       = q_valid && q_ready;
   assign q_chunk   = queue_ff[rd_ptr_ff];

   always_comb begin
      chunk_in.data  = req_data_bits;
      chunk_in.count = (req_bit_count > CHUNK_LIMIT) ? CHUNK_LIMIT : req_bit_count;
      wr_ptr_in      = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in      = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in        = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= chunk_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

FILE: hdl/rdsgrp_back.sv
module rdsgrp_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   output logic                          q_ready,
   input  rdsgrp_pkg::chunk_type         q_chunk,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rdsgrp_pkg::INFO_W-1:0] rsp_block_a_data,
   output logic [rdsgrp_pkg::INFO_W-1:0] rsp_block_b_data,
   output logic [rdsgrp_pkg::INFO_W-1:0] rsp_block_c_data,
   output logic [rdsgrp_pkg::INFO_W-1:0] rsp_block_d_data,
   output logic [rdsgrp_pkg::KIND_W-1:0] rsp_group_kind
);
   import rdsgrp_pkg::*;

   logic                   busy_ff, busy_in;
   logic [DATA_W-1:0]      data_ff;
   logic [COUNT_W-1:0]     rem_ff, rem_in;
   logic [BLOCK_BITS-1:0]  window_ff, window_in;
   logic [SEEN_W-1:0]      seen_ff, seen_in, seen_sat;
   logic [1:0]             expect_ff, expect_in;
   logic [INFO_W-1:0]      words_ff [3];
   logic                   out_valid_ff, out_valid_in;
   logic [INFO_W-1:0]      out_a_ff, out_b_ff, out_c_ff, out_d_ff;
   logic [KIND_W-1:0]      out_kind_ff;

   logic                   load, step, stall, emit, store;
   logic [4:0]             bit_idx;
   logic [2:0]             match;
   logic [1:0]             match_blk;
   logic                   match_ok;
   logic [INFO_W-1:0]      info;

   assign q_ready = !busy_ff;
   assign load    = q_valid && q_ready;
   assign bit_idx = 5'(rem_ff - 6'd1);

   always_comb begin
      window_in = {window_ff[BLOCK_BITS-2:0], data_ff[bit_idx]};
      seen_sat  = (seen_ff < SEEN_FULL) ? seen_ff + 5'd1 : seen_ff;
      match     = classify(window_in);
      info      = window_in[BLOCK_BITS-1:SYN_W];
      // C' stands in for C only where C is awaited
      match_blk = (match == MATCH_CP) ? BLK_C : match[1:0];
      match_ok  = (match != MATCH_NONE) && (match_blk == expect_ff) &&
                  ((match != MATCH_CP) || (expect_ff == BLK_C));
      emit      = busy_ff && (seen_sat == SEEN_FULL) && match_ok && (expect_ff == BLK_D);
      stall     = emit && out_valid_ff && !rsp_ready;
      step      = busy_ff && !stall;
      store     = step && (seen_sat == SEEN_FULL) && match_ok && (expect_ff != BLK_D);

      seen_in   = seen_ff;
      expect_in = expect_ff;
      if (step) begin
         seen_in = seen_sat;
         if (seen_sat == SEEN_FULL) begin
            if (match == MATCH_NONE) begin
               if (expect_ff != BLK_A) begin
                  expect_in = BLK_A;
                  seen_in   = '0;
               end
            end else if (match_ok) begin
               seen_in   = '0;
               expect_in = (expect_ff == BLK_D) ? BLK_A : expect_ff + 2'd1;
            end
         end
      end

      busy_in = busy_ff;
      rem_in  = rem_ff;
      if (load) begin
         busy_in = 1'b1;
         rem_in  = q_chunk.count;
      end else if (step) begin
         rem_in  = rem_ff - 6'd1;
         busy_in = (rem_ff != 6'd1);
      end

      out_valid_in = out_valid_ff && !rsp_ready;
      if (step && emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= q_chunk.data;
      end
      if (store) begin
         words_ff[expect_ff] <= info;
      end
      if (step && emit) begin
         out_a_ff    <= words_ff[0];
         out_b_ff    <= words_ff[1];
         out_c_ff    <= words_ff[2];
         out_d_ff    <= info;
         out_kind_ff <= words_ff[1][INFO_W-1:INFO_W-KIND_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rem_ff       <= '0;
         window_ff    <= '0;
         seen_ff      <= '0;
         expect_ff    <= BLK_A;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rem_ff       <= rem_in;
         if (step) begin
            window_ff <= window_in;
         end
         seen_ff      <= seen_in;
         expect_ff    <= expect_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_block_a_data = out_a_ff;
   assign rsp_block_b_data = out_b_ff;
   assign rsp_block_c_data = out_c_ff;
   assign rsp_block_d_data = out_d_ff;
   assign rsp_group_kind   = out_kind_ff;

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= SEEN_FULL)
      else $error("bit count above block length");

   a_busy_has_bits: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff != '0) && (rem_ff <= CHUNK_LIMIT))
      else $error("busy with no bits left");

   a_emit_restarts: assert property (@(posedge clock) disable iff (reset)
      (step && emit) |=> (expect_ff == BLK_A) && (seen_ff == '0) && out_valid_ff)
      else $error("group emit did not restart at block A");

   a_no_load_when_busy: assert property (@(posedge clock) disable iff (reset)
      load |-> !busy_ff)
      else $error("chunk loaded while busy");

endmodule

FILE: hdl/rds_block_sync_group_assembler_core.sv
// RDS block synchronizer and group assembler.
// Input channel (req_*): one item carries up to 32 received bits in
// req_data_bits; the lowest req_bit_count bits are used, MSB first. Counts
// above 32 are clipped to 32, a count of zero is taken and dropped.
// Output channel (rsp_*): one item per completed A-B-C(C')-D group, carrying
// the four 16-bit information words and the group type from block B.
// Items pass through a two-entry queue into a bit-serial sync engine that
// shifts one bit per cycle, unless held as below, into the 26-bit window
// and checks its syndrome. The engine takes the next item only once all
// bits of the current one are shifted; a group appears on rsp_valid in the
// cycle after the last bit of its block D is shifted.
// The group sits in an output register, so the engine keeps working while
// the receiver stalls; it only holds on a bit that would complete another
// group while that register is still full. Input backpressure follows once
// the queue is full. Reset (synchronous) clears the window, the bit count,
// the queue and the output register, and expects block A.
module rds_block_sync_group_assembler_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [rdsgrp_pkg::DATA_W-1:0]  req_data_bits,
   input  logic [rdsgrp_pkg::COUNT_W-1:0] req_bit_count,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [rdsgrp_pkg::INFO_W-1:0]  rsp_block_a_data,
   output logic [rdsgrp_pkg::INFO_W-1:0]  rsp_block_b_data,
   output logic [rdsgrp_pkg::INFO_W-1:0]  rsp_block_c_data,
   output logic [rdsgrp_pkg::INFO_W-1:0]  rsp_block_d_data,
   output logic [rdsgrp_pkg::KIND_W-1:0]  rsp_group_kind
);
   import rdsgrp_pkg::*;

   logic      q_valid;
   logic      q_ready;
   chunk_type q_chunk;

   rdsgrp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_bits (req_data_bits),
      .req_bit_count (req_bit_count),
      .q_valid       (q_valid),
      .q_ready       (q_ready),
      .q_chunk       (q_chunk)
   );

   rdsgrp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_ready          (q_ready),
      .q_chunk          (q_chunk),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_block_a_data (rsp_block_a_data),
      .rsp_block_b_data (rsp_block_b_data),
      .rsp_block_c_data (rsp_block_c_data),
      .rsp_block_d_data (rsp_block_d_data),
      .rsp_group_kind   (rsp_group_kind)
   );

endmodule

FILE: dv/tb_rds_block_sync_group_assembler_core.sv
`timescale 1ns / 100ps

module tb_rds_block_sync_group_assembler_core;
   import rdsgrp_pkg::*;

   typedef struct packed {
      logic [INFO_W-1:0] a;
      logic [INFO_W-1:0] b;
      logic [INFO_W-1:0] c;
      logic [INFO_W-1:0] d;
      logic [KIND_W-1:0] kind;
   } rds_group_type;

   typedef enum {RX_STEADY, RX_RANDOM, RX_SPARSE} rx_mode_type;

   class group_scoreboard;
      logic [BLOCK_BITS-1:0] window;
      int                    seen;
      logic [1:0]            awaited;
      logic [INFO_W-1:0]     words [3];
      rds_group_type         groups_due [$];
      int                    errors;

      function new();
         window  = '0;
         seen    = 0;
         awaited = BLK_A;
         errors  = 0;
         foreach (words[i]) words[i] = '0;
      endfunction

      // k counts from the window MSB
      function logic [SYN_W-1:0] parity_row(int k);
         case (k)
            0:  return 10'h200;  1: return 10'h100;  2: return 10'h080;
            3:  return 10'h040;  4: return 10'h020;  5: return 10'h010;
            6:  return 10'h008;  7: return 10'h004;  8: return 10'h002;
            9:  return 10'h001; 10: return 10'h2dc; 11: return 10'h16e;
            12: return 10'h0b7; 13: return 10'h287; 14: return 10'h39f;
            15: return 10'h313; 16: return 10'h355; 17: return 10'h376;
            18: return 10'h1bb; 19: return 10'h201; 20: return 10'h3dc;
            21: return 10'h1ee; 22: return 10'h0f7; 23: return 10'h2a7;
            24: return 10'h38f; default: return 10'h31b;
         endcase
      endfunction

      function logic [SYN_W-1:0] syndrome_of(logic [BLOCK_BITS-1:0] w);
         logic [SYN_W-1:0] s;
         s = '0;
         for (int k = 0; k < BLOCK_BITS; k++)
            if (w[BLOCK_BITS-1-k]) s = s ^ parity_row(k);
         return s;
      endfunction

      function logic [2:0] match_offset(logic [BLOCK_BITS-1:0] w);
         logic [SYN_W-1:0] s;
         s = syndrome_of(w);
         if (s == OFS_A)  return MATCH_A;
         if (s == OFS_B)  return MATCH_B;
         if (s == OFS_C)  return MATCH_C;
         if (s == OFS_D)  return MATCH_D;
         if (s == OFS_CP) return MATCH_CP;
         return MATCH_NONE;
      endfunction

      function void take_chunk(logic [DATA_W-1:0] data, logic [COUNT_W-1:0] count);
         int                n;
         logic [2:0]        found;
         logic [INFO_W-1:0] info;
         rds_group_type     g;
         n = (count > CHUNK_LIMIT) ? MAX_CHUNK_BITS : int'(count);
         for (int i = n - 1; i >= 0; i--) begin
            window = {window[BLOCK_BITS-2:0], data[i]};
            if (seen < BLOCK_BITS) seen++;
            if (seen < BLOCK_BITS) continue;
            found = match_offset(window);
            if (found == MATCH_NONE) begin
               // bad checkword inside a group: resync on A
               if (awaited != BLK_A) begin
                  awaited = BLK_A;
                  seen    = 0;
               end
               continue;
            end
            if (found == MATCH_CP && awaited == BLK_C) found = MATCH_C;
            if (found != {1'b0, awaited}) continue;
            seen = 0;
            info = window[BLOCK_BITS-1:SYN_W];
            if (awaited == BLK_D) begin
               g.a    = words[0];
               g.b    = words[1];
               g.c    = words[2];
               g.d    = info;
               g.kind = words[1][15:11];
               groups_due.push_back(g);
               awaited = BLK_A;
            end else begin
               words[awaited] = info;
               awaited = awaited + 2'd1;
            end
         end
      endfunction

      function int pending();
         return groups_due.size();
      endfunction

      function void compare_field(string name, logic [INFO_W-1:0] want, logic [INFO_W-1:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
         end
      endfunction

      function void check_group(rds_group_type got);
         rds_group_type want;
         if (groups_due.size() == 0) begin
            errors++;
            $display("%0t: group not expected, actual a=%h b=%h c=%h d=%h kind=%h",
                     $time, got.a, got.b, got.c, got.d, got.kind);
            return;
         end
         want = groups_due.pop_front();
         compare_field("block_a_data", want.a, got.a);
         compare_field("block_b_data", want.b, got.b);
         compare_field("block_c_data", want.c, got.c);
         compare_field("block_d_data", want.d, got.d);
         compare_field("group_kind", INFO_W'(want.kind), INFO_W'(got.kind));
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [DATA_W-1:0]   req_data_bits;
   logic [COUNT_W-1:0]  req_bit_count;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [INFO_W-1:0]   rsp_block_a_data;
   logic [INFO_W-1:0]   rsp_block_b_data;
   logic [INFO_W-1:0]   rsp_block_c_data;
   logic [INFO_W-1:0]   rsp_block_d_data;
   logic [KIND_W-1:0]   rsp_group_kind;

   group_scoreboard     sb = new();
   logic [SYN_W-1:0]    check_for_syn [1024];
   bit                  rx_bits [$];
   int                  burst_left;
   bit                  long_hold_req;

   rds_block_sync_group_assembler_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_bits    (req_data_bits),
      .req_bit_count    (req_bit_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_block_a_data (rsp_block_a_data),
      .rsp_block_b_data (rsp_block_b_data),
      .rsp_block_c_data (rsp_block_c_data),
      .rsp_block_d_data (rsp_block_d_data),
      .rsp_group_kind   (rsp_group_kind)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- bit stream

   function automatic logic [SYN_W-1:0] offset_code(int idx);
      case (idx)
         0:       return OFS_A;
         1:       return OFS_B;
         2:       return OFS_C;
         3:       return OFS_D;
         default: return OFS_CP;
      endcase
   endfunction

   function automatic void push_block(logic [INFO_W-1:0] info, logic [SYN_W-1:0] ofs);
      logic [BLOCK_BITS-1:0] blk;
      blk[BLOCK_BITS-1:SYN_W] = info;
      blk[SYN_W-1:0] = check_for_syn[ofs ^ sb.syndrome_of({info, 10'b0})];
      for (int k = BLOCK_BITS - 1; k >= 0; k--) rx_bits.push_back(blk[k]);
   endfunction

   function automatic void push_noise(int n);
      repeat (n) rx_bits.push_back(1'($urandom_range(0, 1)));
   endfunction

   // flip_at < 0 leaves the group intact
   function automatic void push_group(bit use_cprime, int flip_at);
      int base;
      base = rx_bits.size();
      push_block(16'($urandom), OFS_A);
      push_block(16'($urandom), OFS_B);
      push_block(16'($urandom), use_cprime ? OFS_CP : OFS_C);
      push_block(16'($urandom), OFS_D);
      if (flip_at >= 0) rx_bits[base + flip_at] = ~rx_bits[base + flip_at];
   endfunction

   function automatic void refill_stream();
      int r;
      r = $urandom_range(0, 99);
      if (r < 62) begin
         push_group($urandom_range(0, 3) == 0, -1);
      end else if (r < 72) begin
         push_noise($urandom_range(1, 60));
      end else if (r < 82) begin
         push_group(1'($urandom_range(0, 1)), $urandom_range(0, 4 * BLOCK_BITS - 1));
      end else if (r < 90) begin
         repeat ($urandom_range(1, 4))
            push_block(16'($urandom), offset_code($urandom_range(0, 4)));
      end else begin
         // group cut short
         push_block(16'($urandom), OFS_A);
         push_block(16'($urandom), OFS_B);
         if ($urandom_range(0, 1)) push_block(16'($urandom), OFS_C);
      end
   endfunction

   function automatic logic [COUNT_W-1:0] pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4)  return '0;
      if (r < 10) return COUNT_W'($urandom_range(33, 63));
      if (r < 20) return CHUNK_LIMIT;
      if (r < 28) return COUNT_W'(BLOCK_BITS);
      if (r < 35) return COUNT_W'($urandom_range(1, 3));
      return COUNT_W'($urandom_range(4, 31));
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_chunk(input logic [DATA_W-1:0] d, input logic [COUNT_W-1:0] c);
      req_valid     <= 1'b1;
      req_data_bits <= d;
      req_bit_count <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.take_chunk(d, c);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
      end
   endtask

   task automatic send_stream_chunk(input logic [COUNT_W-1:0] c);
      int                n;
      logic [DATA_W-1:0] d;
      n = (c > CHUNK_LIMIT) ? MAX_CHUNK_BITS : int'(c);
      while (rx_bits.size() < n) refill_stream();
      d = $urandom;
      for (int k = n - 1; k >= 0; k--) d[k] = rx_bits.pop_front();
      send_chunk(d, c);
   endtask

   // receiver: checks results and stalls on its own pattern
   initial begin
      rx_mode_type   mode;
      int            mode_left;
      int            hold_left;
      rds_group_type got;
      rsp_ready <= 1'b0;
      mode      = RX_STEADY;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.a    = rsp_block_a_data;
            got.b    = rsp_block_b_data;
            got.c    = rsp_block_c_data;
            got.d    = rsp_block_d_data;
            got.kind = rsp_group_kind;
            sb.check_group(got);
         end
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = 600;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = rx_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (mode)
               RX_STEADY: rsp_ready <= 1'b1;
               RX_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
               default:   rsp_ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data_bits <= '0;
      req_bit_count <= '0;
      burst_left    = 0;
      long_hold_req = 1'b0;
      for (int c = 0; c < 1024; c++) check_for_syn[sb.syndrome_of(BLOCK_BITS'(c))] = SYN_W'(c);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // field extremes: empty chunk, oversized chunk, full chunk, single bit
      send_chunk('1, '0);
      send_chunk('0, '1);
      send_chunk('1, CHUNK_LIMIT);
      send_chunk($urandom, COUNT_W'(1));

      // all-ones group, then all-zeros group carried by C'
      push_block(16'hffff, OFS_A);
      push_block(16'hffff, OFS_B);
      push_block(16'hffff, OFS_C);
      push_block(16'hffff, OFS_D);
      push_block(16'h0000, OFS_A);
      push_block(16'h0000, OFS_B);
      push_block(16'h0000, OFS_CP);
      push_block(16'h0000, OFS_D);
      // C' while B is awaited is out of sequence
      push_block(16'($urandom), OFS_A);
      push_block(16'($urandom), OFS_CP);
      push_block(16'($urandom), OFS_B);
      push_block(16'($urandom), OFS_C);
      push_block(16'($urandom), OFS_D);
      // bad checkword in mid-group, then a stray D
      push_group(1'b0, 2 * BLOCK_BITS + 7);
      // D while C is awaited is ignored
      push_block(16'($urandom), OFS_A);
      push_block(16'($urandom), OFS_B);
      push_block(16'($urandom), OFS_D);
      push_block(16'($urandom), OFS_C);
      push_block(16'($urandom), OFS_D);
      while (rx_bits.size() >= MAX_CHUNK_BITS) send_stream_chunk(CHUNK_LIMIT);

      for (int item = 0; item < 1500; item++) begin
         if (item == 400) long_hold_req = 1'b1;
         if (item == 900) begin
            // drain everything before going on
            req_valid <= 1'b0;
            burst_left = 0;
            @(posedge clock);
            while (sb.pending() != 0) @(posedge clock);
         end
         send_stream_chunk(pick_count());
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (sb.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
